FILE: rtl/ecf_pkg.sv
package ecf_pkg;

    // Matrix size; vertex numbers are fixed at 4 bits, so the range is 2..15.
    localparam int MAX_VERTICES = 8;
    localparam int STACK_DEPTH  = MAX_VERTICES * (MAX_VERTICES - 1) / 2 + 1;

    localparam int VTX_W      = 4;
    localparam int IDX_W      = $clog2(MAX_VERTICES);
    localparam int PTR_W      = $clog2(STACK_DEPTH + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // Item commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Result status
    localparam logic STATUS_VERTEX = 1'b0;
    localparam logic STATUS_FAIL   = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_START_VERTEX = CFG_IDX_W'(1);

    localparam logic [VTX_W-1:0] VERTEX_COUNT_RST = VTX_W'(8);
    localparam logic [VTX_W-1:0] START_VERTEX_RST = VTX_W'(1);

    function automatic logic in_matrix(input logic [VTX_W-1:0] v);
        in_matrix = (v != '0) && (v <= VTX_W'(MAX_VERTICES));
    endfunction

endpackage

FILE: rtl/ecf_if.sv
interface ecf_req_if;
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [ecf_pkg::VTX_W-1:0] row_vertex;
    logic [ecf_pkg::VTX_W-1:0] col_vertex;
    logic                      edge_bit;

    modport source (output valid, cmd, row_vertex, col_vertex, edge_bit, input ready);
    modport sink   (input valid, cmd, row_vertex, col_vertex, edge_bit, output ready);
endinterface

interface ecf_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [ecf_pkg::VTX_W-1:0] vertex;
    logic                      status;
    logic                      last;

    modport source (output valid, vertex, status, last, input ready);
    modport sink   (input valid, vertex, status, last, output ready);
endinterface

interface ecf_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ecf_pkg::CFG_IDX_W-1:0]  index;
    logic [ecf_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/euler_circuit_finder.sv
// Euler circuit finder on an adjacency matrix held in flip-flops (cleared by
// reset, no clearing pass). A write item (cmd 0) sets one entry, not its
// mirror. A start item (cmd 1) first checks the parity of rows 1..n
// (n = vertex_count, capped at the matrix size), then takes one walk step
// per cycle, then emits one vertex per cycle while the result side keeps
// up. All of this runs through one shared row-read and lowest-neighbor
// search unit under a small sequencer; the block takes no new item until
// the run's last result is in the output register. An odd row sum or a
// walk longer than the edge bound gives a single failure result (vertex 0,
// status 1, last 1). Edges used by a walk stay deleted. Configuration
// writes are always taken; make them while idle.
module euler_circuit_finder (
    input  logic          clk,
    input  logic          rst_n,
    ecf_cfg_if.sink       cfg,
    ecf_req_if.sink       req,
    ecf_rsp_if.source     rsp
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PARITY = 5'b00010,
        ST_WALK   = 5'b00100,
        ST_FAIL   = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    localparam int VW = ecf_pkg::VTX_W;
    localparam int MV = ecf_pkg::MAX_VERTICES;
    localparam int PW = ecf_pkg::PTR_W;

    state_t state_reg, state_next;

    // config
    logic [VW-1:0] vertex_count_reg;
    logic [VW-1:0] start_vertex_reg;

    // matrix rows, bit j of row i = entry (i+1, j+1)
    logic [MV-1:0] adj_reg [MV];

    logic [VW-1:0] walk_stack_reg    [ecf_pkg::STACK_DEPTH];
    logic [VW-1:0] circuit_store_reg [ecf_pkg::STACK_DEPTH];

    logic [PW-1:0] top_reg,  top_next;
    logic [PW-1:0] cnt_reg,  cnt_next;
    logic [PW-1:0] used_reg, used_next;
    logic [VW-1:0] n_reg,    n_next;
    logic [VW-1:0] row_reg,  row_next;

    logic          out_valid_reg, out_valid_next;
    logic [VW-1:0] out_vertex_reg, out_vertex_next;
    logic          out_status_reg, out_status_next;
    logic          out_last_reg,   out_last_next;

    logic          req_xfer;
    logic          cfg_xfer;
    logic          out_free;
    logic          out_load;
    logic          init_en;
    logic          push_en;
    logic          pop_en;

    logic [VW-1:0] top_vertex;
    logic [VW-1:0] row_sel;
    logic [MV-1:0] col_mask;
    logic [MV-1:0] scan_row;
    logic          hit;
    logic [ecf_pkg::IDX_W-1:0] hit_idx;
    logic [VW-1:0] hit_vertex;

    assign req_xfer  = req.valid && req.ready;
    assign cfg_xfer  = cfg.valid && cfg.ready;
    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;

    assign rsp.valid  = out_valid_reg;
    assign rsp.vertex = out_vertex_reg;
    assign rsp.status = out_status_reg;
    assign rsp.last   = out_last_reg;

    // ---------------------------------------------------------------
    // Shared unit: read one row (parity row or top-of-stack vertex),
    // mask to the active columns, find the lowest neighbor.
    // ---------------------------------------------------------------
    assign top_vertex = walk_stack_reg[PW'(top_reg - PW'(1))];
    assign row_sel    = (state_reg == ST_PARITY) ? row_reg : top_vertex;

    always_comb
    begin
        for (int j = 0; j < MV; j++)
        begin
            col_mask[j] = (VW'(j) < n_reg);
        end
    end

    assign scan_row = ecf_pkg::in_matrix(row_sel)
                    ? (adj_reg[ecf_pkg::IDX_W'(row_sel - VW'(1))] & col_mask)
                    : '0;

    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int j = MV - 1; j >= 0; j--)
        begin
            if (scan_row[j])
            begin
                hit     = 1'b1;
                hit_idx = ecf_pkg::IDX_W'(j);
            end
        end
    end

    assign hit_vertex = VW'(hit_idx) + VW'(1);

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        top_next        = top_reg;
        cnt_next        = cnt_reg;
        used_next       = used_reg;
        n_next          = n_reg;
        row_next        = row_reg;
        out_load        = 1'b0;
        out_vertex_next = out_vertex_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        init_en         = 1'b0;
        push_en         = 1'b0;
        pop_en          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer && (req.cmd == ecf_pkg::CMD_START))
                begin
                    n_next     = (vertex_count_reg > VW'(MV)) ? VW'(MV) : vertex_count_reg;
                    row_next   = VW'(1);
                    state_next = ST_PARITY;
                end
            end
            ST_PARITY:
            begin
                if (row_reg > n_reg)
                begin
                    init_en    = 1'b1;
                    top_next   = PW'(1);
                    cnt_next   = '0;
                    used_next  = '0;
                    state_next = ST_WALK;
                end
                else if (^scan_row)
                begin
                    state_next = ST_FAIL;
                end
                else
                begin
                    row_next = row_reg + VW'(1);
                end
            end
            ST_WALK:
            begin
                if (!hit)
                begin
                    // dead end: vertex joins the circuit
                    pop_en   = 1'b1;
                    cnt_next = cnt_reg + PW'(1);
                    top_next = top_reg - PW'(1);
                    if (top_reg == PW'(1))
                    begin
                        state_next = ST_EMIT;
                    end
                end
                else if (used_reg >= PW'(ecf_pkg::STACK_DEPTH - 1))
                begin
                    state_next = ST_FAIL;
                end
                else
                begin
                    push_en   = 1'b1;
                    used_next = used_reg + PW'(1);
                    top_next  = top_reg + PW'(1);
                end
            end
            ST_FAIL:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_vertex_next = '0;
                    out_status_next = ecf_pkg::STATUS_FAIL;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                // circuit leaves in reverse pop order
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_vertex_next = circuit_store_reg[PW'(cnt_reg - PW'(1))];
                    out_status_next = ecf_pkg::STATUS_VERTEX;
                    out_last_next   = (cnt_reg == PW'(1));
                    cnt_next        = cnt_reg - PW'(1);
                    if (cnt_reg == PW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            top_reg          <= '0;
            cnt_reg          <= '0;
            used_reg         <= '0;
            n_reg            <= '0;
            row_reg          <= '0;
            out_valid_reg    <= 1'b0;
            vertex_count_reg <= ecf_pkg::VERTEX_COUNT_RST;
            start_vertex_reg <= ecf_pkg::START_VERTEX_RST;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            cnt_reg       <= cnt_next;
            used_reg      <= used_next;
            n_reg         <= n_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            if (cfg_xfer)
            begin
                if (cfg.index == ecf_pkg::REG_VERTEX_COUNT)
                begin
                    vertex_count_reg <= VW'(cfg.data);
                end
                else if (cfg.index == ecf_pkg::REG_START_VERTEX)
                begin
                    start_vertex_reg <= VW'(cfg.data);
                end
            end
        end
    end

    // Matrix: loads from write items, edge and mirror deleted on each push
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MV; i++)
            begin
                adj_reg[i] <= '0;
            end
        end
        else
        begin
            if (req_xfer && (req.cmd == ecf_pkg::CMD_WRITE)
                && ecf_pkg::in_matrix(req.row_vertex) && ecf_pkg::in_matrix(req.col_vertex))
            begin
                adj_reg[ecf_pkg::IDX_W'(req.row_vertex - VW'(1))]
                       [ecf_pkg::IDX_W'(req.col_vertex - VW'(1))] <= req.edge_bit;
            end
            if (push_en)
            begin
                adj_reg[ecf_pkg::IDX_W'(top_vertex - VW'(1))][hit_idx] <= 1'b0;
                adj_reg[hit_idx][ecf_pkg::IDX_W'(top_vertex - VW'(1))] <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (init_en)
        begin
            walk_stack_reg[0] <= start_vertex_reg;
        end
        if (push_en)
        begin
            walk_stack_reg[top_reg] <= hit_vertex;
        end
        if (pop_en)
        begin
            circuit_store_reg[cnt_reg] <= top_vertex;
        end
        if (out_load)
        begin
            out_vertex_reg <= out_vertex_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
        end
    end

`ifndef SYNTHESIS
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= PW'(ecf_pkg::STACK_DEPTH))
        else $error("walk stack pointer past its depth");

    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (top_reg != '0))
        else $error("walk step with empty stack");

    a_fail_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == ecf_pkg::STATUS_FAIL))
            |-> (out_last_reg && (out_vertex_reg == '0)))
        else $error("failure result malformed");

    a_start_parity: assert property (@(posedge clk) disable iff (!rst_n)
        (req_xfer && (req.cmd == ecf_pkg::CMD_START)) |=> (state_reg == ST_PARITY))
        else $error("start transfer did not begin parity check");
`endif

endmodule

FILE: tb/euler_circuit_finder_tb.sv
module euler_circuit_finder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ecf_pkg::*;

    // Quiet cycles allowed after the last result before a register write or the end,
    // and the number of cycles without any transfer that counts as a hang.
    localparam int IDLE_SETTLE  = 20;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 160;

    typedef struct packed {
        logic             cmd;
        logic [VTX_W-1:0] row_vertex;
        logic [VTX_W-1:0] col_vertex;
        logic             edge_bit;
    } matrix_item_t;

    typedef struct packed {
        logic [VTX_W-1:0] vertex;
        logic             status;
        logic             last;
    } circuit_step_t;

    logic clk;
    logic rst_n;

    ecf_cfg_if cfg_bus ();
    ecf_req_if req_bus ();
    ecf_rsp_if rsp_bus ();

    euler_circuit_finder uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Shadow copy of the matrix and registers; row/column 0 are never set.
    bit               adj_m [0:MAX_VERTICES][0:MAX_VERTICES];
    logic [VTX_W-1:0] vcount_m;
    logic [VTX_W-1:0] start_m;

    matrix_item_t  pending_q [$];   // items waiting to be driven
    circuit_step_t circuit_q [$];   // circuit vertices still owed by the block
    matrix_item_t  held_item;
    circuit_step_t head;
    bit            req_fired;
    bit            send_steady;
    bit            recv_steady;
    int            send_gap;
    int            recv_stall;
    int            err_count;
    int            idle_cycles;
    int            live_items;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Circuit predictor
    // ------------------------------------------------------------------
    function automatic bit grid_bit(int r, int c);
        if (r < 1 || r > MAX_VERTICES || c < 1 || c > MAX_VERTICES)
            return 1'b0;
        return adj_m[r][c];
    endfunction

    function automatic void grid_set(int r, int c, bit b);
        if (r >= 1 && r <= MAX_VERTICES && c >= 1 && c <= MAX_VERTICES)
            adj_m[r][c] = b;
    endfunction

    // Matrix write, or parity check followed by the lowest-neighbor walk.
    function automatic void predict_circuit(matrix_item_t it);
        int               n;
        int               sum;
        int               top;
        int               cnt;
        int               used;
        int               v;
        int               x;
        logic [VTX_W-1:0] walk_stk [STACK_DEPTH];
        logic [VTX_W-1:0] found    [STACK_DEPTH];
        circuit_step_t    fail_step;
        circuit_step_t    step;

        fail_step.vertex = '0;
        fail_step.status = STATUS_FAIL;
        fail_step.last   = 1'b1;

        if (it.cmd == CMD_WRITE)
        begin
            // only the addressed entry, never its mirror
            grid_set(it.row_vertex, it.col_vertex, it.edge_bit);
            return;
        end

        n = (vcount_m > MAX_VERTICES) ? MAX_VERTICES : int'(vcount_m);

        // any odd row sum: single failure, matrix untouched
        for (int i = 1; i <= n; i++)
        begin
            sum = 0;
            for (int j = 1; j <= n; j++)
                sum += grid_bit(i, j);
            if (sum % 2 != 0)
            begin
                circuit_q.push_back(fail_step);
                return;
            end
        end

        top         = 1;
        walk_stk[0] = start_m;
        cnt         = 0;
        used        = 0;
        while (top != 0)
        begin
            v = walk_stk[top-1];
            x = 1;
            while (x <= n && !grid_bit(v, x))
                x++;
            if (x > n)
            begin
                found[cnt] = VTX_W'(v);
                cnt++;
                top--;
            end
            else
            begin
                // walk longer than the edge bound: abort, deletions so far stay
                if (used >= STACK_DEPTH - 1)
                begin
                    circuit_q.push_back(fail_step);
                    return;
                end
                used++;
                walk_stk[top] = VTX_W'(x);
                top++;
                grid_set(v, x, 1'b0);
                grid_set(x, v, 1'b0);
            end
        end

        // last popped comes out first
        for (int k = cnt; k > 0; k--)
        begin
            step.vertex = found[k-1];
            step.status = STATUS_VERTEX;
            step.last   = (k == 1);
            circuit_q.push_back(step);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic void queue_item(logic cmd, int r, int c, bit b);
        matrix_item_t it;
        it.cmd        = cmd;
        it.row_vertex = VTX_W'(r);
        it.col_vertex = VTX_W'(c);
        it.edge_bit   = b;
        pending_q.push_back(it);
        live_items++;
    endfunction

    function automatic void queue_start();
        queue_item(CMD_START, $urandom_range(15, 0), $urandom_range(15, 0), $urandom_range(1));
    endfunction

    function automatic void queue_noise();
        queue_item(CMD_WRITE, $urandom_range(15, 0), $urandom_range(15, 0), $urandom_range(1));
    endfunction

    // Symmetric cycle over distinct vertices of 1..n, through anchor when it is in range.
    function automatic void queue_cycle(int n, int anchor);
        int perm [1:MAX_VERTICES];
        int len;
        int j;
        int tmp;
        int a;
        int b;

        for (int i = 1; i <= n; i++)
            perm[i] = i;
        for (int i = n; i >= 2; i--)
        begin
            j       = $urandom_range(i, 1);
            tmp     = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        if (anchor >= 1 && anchor <= n)
        begin
            for (int i = 1; i <= n; i++)
                if (perm[i] == anchor)
                begin
                    perm[i] = perm[1];
                    perm[1] = anchor;
                end
        end
        len = $urandom_range(n, 3);
        for (int i = 1; i <= len; i++)
        begin
            a = perm[i];
            b = perm[(i == len) ? 1 : i + 1];
            queue_item(CMD_WRITE, a, b, 1'b1);
            queue_item(CMD_WRITE, b, a, 1'b1);
        end
    endfunction

    // Register write; only called with the block idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= CFG_DATA_W'(val);
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        if (idx == REG_VERTEX_COUNT)
            vcount_m = CFG_DATA_W'(val);
        else if (idx == REG_START_VERTEX)
            start_m = CFG_DATA_W'(val);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Hold the sender until every owed result is in, then let the block settle.
    task automatic drain();
        while (pending_q.size() != 0 || req_bus.valid || circuit_q.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Request driver: predict on the transfer edge, drive at the falling edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        req_fired = rst_n && req_bus.valid && req_bus.ready;
        if (req_fired)
            predict_circuit(held_item);
    end

    always @(negedge clk)
    begin
        // keep an item up until it transfers
        if (rst_n && !(req_bus.valid && !req_fired))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                req_bus.valid <= 1'b0;
            end
            else if (pending_q.size() != 0)
            begin
                held_item = pending_q.pop_front();
                req_bus.valid      <= 1'b1;
                req_bus.cmd        <= held_item.cmd;
                req_bus.row_vertex <= held_item.row_vertex;
                req_bus.col_vertex <= held_item.col_vertex;
                req_bus.edge_bit   <= held_item.edge_bit;
                send_gap = send_steady ? 0 : pick_gap();
            end
            else
                req_bus.valid <= 1'b0;
        end
    end

    // Result side backpressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (recv_stall > 0)
            begin
                recv_stall--;
                rsp_bus.ready <= 1'b0;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
                if (!recv_steady && $urandom_range(99) < 30)
                    recv_stall = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (circuit_q.size() == 0)
            begin
                $display("%0t: unexpected result vertex=%0d status=%0d last=%0d",
                         $time, rsp_bus.vertex, rsp_bus.status, rsp_bus.last);
                err_count++;
            end
            else
            begin
                head = circuit_q.pop_front();
                if (rsp_bus.vertex !== head.vertex || rsp_bus.status !== head.status ||
                    rsp_bus.last !== head.last)
                begin
                    $display("%0t: mismatch exp v=%0d s=%0d l=%0d got v=%0d s=%0d l=%0d",
                             $time, head.vertex, head.status, head.last,
                             rsp_bus.vertex, rsp_bus.status, rsp_bus.last);
                    err_count++;
                end
            end
        end
    end

    // Hang detection: no transfer on any channel for too long
    always @(posedge clk)
    begin
        if (rst_n && ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
                      (cfg_bus.valid && cfg_bus.ready)))
            idle_cycles = 0;
        else if (rst_n)
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int vc;
        int n;
        int sv;

        req_bus.valid      = 1'b0;
        req_bus.cmd        = CMD_WRITE;
        req_bus.row_vertex = '0;
        req_bus.col_vertex = '0;
        req_bus.edge_bit   = 1'b0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = REG_VERTEX_COUNT;
        cfg_bus.data       = '0;
        rsp_bus.ready      = 1'b0;
        vcount_m    = VERTEX_COUNT_RST;
        start_m     = START_VERTEX_RST;
        send_gap    = 0;
        recv_stall  = 0;
        send_steady = 1'b0;
        recv_steady = 1'b0;
        err_count   = 0;
        idle_cycles = 0;
        live_items  = 0;

        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Empty matrix after reset: the start vertex alone
        queue_start();
        // Triangle 1-2-3, then writes outside the matrix that must be dropped
        queue_item(CMD_WRITE, 1, 2, 1'b1);
        queue_item(CMD_WRITE, 2, 1, 1'b1);
        queue_item(CMD_WRITE, 2, 3, 1'b1);
        queue_item(CMD_WRITE, 3, 2, 1'b1);
        queue_item(CMD_WRITE, 1, 3, 1'b1);
        queue_item(CMD_WRITE, 3, 1, 1'b1);
        queue_item(CMD_WRITE, 0, 5, 1'b1);
        queue_item(CMD_WRITE, 9, 1, 1'b1);
        queue_item(CMD_WRITE, 15, 15, 1'b1);
        queue_item(CMD_WRITE, 3, 0, 1'b1);
        queue_start();
        // one-way entry: odd row, failure; then cleared again
        queue_item(CMD_WRITE, 5, 6, 1'b1);
        queue_start();
        queue_item(CMD_WRITE, 5, 6, 1'b0);
        // self loops on 4 and 7 joined by an edge; start 1 sees nothing
        queue_item(CMD_WRITE, 4, 4, 1'b1);
        queue_item(CMD_WRITE, 4, 7, 1'b1);
        queue_item(CMD_WRITE, 7, 4, 1'b1);
        queue_item(CMD_WRITE, 7, 7, 1'b1);
        queue_start();
        drain();

        write_reg(REG_START_VERTEX, 4);
        queue_start();
        drain();

        // zero vertices: parity passes, walk finds nothing
        write_reg(REG_VERTEX_COUNT, 0);
        queue_start();
        drain();

        // count above the matrix size, start vertex outside it
        write_reg(REG_VERTEX_COUNT, 15);
        write_reg(REG_START_VERTEX, 15);
        queue_start();
        drain();

        // single vertex with a self loop: odd row sum
        write_reg(REG_VERTEX_COUNT, 1);
        write_reg(REG_START_VERTEX, 1);
        queue_item(CMD_WRITE, 1, 1, 1'b1);
        queue_start();
        drain();

        // Full matrix with loops: even rows but more traversals than the stack allows;
        // the second start runs on what the aborted walk left behind.
        write_reg(REG_VERTEX_COUNT, MAX_VERTICES);
        write_reg(REG_START_VERTEX, $urandom_range(MAX_VERTICES, 1));
        for (int r = 1; r <= MAX_VERTICES; r++)
            for (int c = 1; c <= MAX_VERTICES; c++)
                queue_item(CMD_WRITE, r, c, 1'b1);
        queue_start();
        queue_start();
        drain();

        // Random phases: new registers, then cycle loads ending in a start
        while (live_items < RANDOM_ITEMS)
        begin
            sv = $urandom_range(99);
            if (sv < 8)
                vc = $urandom_range(15, 9);
            else if (sv < 16)
                vc = $urandom_range(2, 0);
            else
                vc = $urandom_range(MAX_VERTICES, 3);
            n = (vc > MAX_VERTICES) ? MAX_VERTICES : vc;
            if (n > 0 && $urandom_range(99) < 80)
                sv = $urandom_range(n, 1);
            else
                sv = $urandom_range(15, 0);
            write_reg(REG_VERTEX_COUNT, vc);
            write_reg(REG_START_VERTEX, sv);

            send_steady = ($urandom_range(3) == 0);
            recv_steady = ($urandom_range(3) == 0);

            repeat ($urandom_range(3, 1))
            begin
                if ($urandom_range(99) < 75 && n >= 3)
                begin
                    repeat ($urandom_range(3, 1))
                        queue_cycle(n, ($urandom_range(2) != 0) ? sv : 0);
                end
                else
                begin
                    repeat ($urandom_range(6, 1))
                        queue_noise();
                end
                if ($urandom_range(9) == 0)
                    queue_noise();
                queue_start();
            end
            drain();
        end

        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
